FILE: hw/rtl/oppg_pkg.sv
// Package: shared types, register indexes, axis codes and CORDIC constants of the orbit generator.
package oppg_pkg;

	localparam int PHASE_BITS_DEF = 32;
	localparam int TRIG_BITS_DEF  = 16;

	localparam int STEP_W     = 16;
	localparam int SPEED_W    = 32;
	localparam int RADIUS_W   = 16;
	localparam int MODE_W     = 3;
	localparam int POS_W      = 17;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	// serial multiplier digit
	localparam int DIGIT_W = 4;

	// angle in units of 2^-32 turn, CORDIC datapath with 30 fraction bits
	localparam int ANGLE_W  = 32;
	localparam int CORDIC_W = 32;
	localparam int CORDIC_FRAC = 30;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

	// placement of sine (S) and cosine (C)
	localparam logic [MODE_W-1:0] AXIS_XY_SC = 3'd0;
	localparam logic [MODE_W-1:0] AXIS_XZ_SC = 3'd1;
	localparam logic [MODE_W-1:0] AXIS_XZ_CS = 3'd2;
	localparam logic [MODE_W-1:0] AXIS_XY_CS = 3'd3;
	localparam logic [MODE_W-1:0] AXIS_YZ_CS = 3'd4;
	localparam logic [MODE_W-1:0] AXIS_YZ_SC = 3'd5;

	localparam logic [CORDIC_W-1:0] CORDIC_GAIN = 32'd652032874;

	localparam int ATAN_N     = 24;
	localparam int ATAN_IDX_W = 5;
	localparam logic [ANGLE_W-1:0] ATAN_TURN [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACCUM,
		ST_ROTATE,
		ST_MAG,
		ST_SCALE,
		ST_FINISH
	} state_t;

endpackage

FILE: hw/rtl/orbit_phase_position_generator_core.sv
// Top level: orbit position generator with phase accumulator, iterative CORDIC and serial scaling.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  input    | in_valid / in_ready    | time_step
//  output   | out_valid / out_ready  | pos_x, pos_y, pos_z
//  config   | cfg_we (no wait)       | cfg_index, cfg_data
//
// One transaction runs through the accept, the digit-serial speed*step product, the phase add,
// TRIG_BITS rotations on the shared CORDIC rotator (the bulk of the work), the magnitude step,
// the radius scaling and the output load.
// Reset clears the phase, the registers and all control state.
// A result that waits on out_ready holds the output register; a new transaction is still
// accepted and runs up to the output load, where it stalls until the register frees.

module orbit_phase_position_generator_core #(
	parameter int PHASE_BITS = oppg_pkg::PHASE_BITS_DEF,
	parameter int TRIG_BITS  = oppg_pkg::TRIG_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_we,
	input  logic [oppg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [oppg_pkg::CFG_DATA_W-1:0]     cfg_data,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [oppg_pkg::STEP_W-1:0]         time_step,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [oppg_pkg::POS_W-1:0]   pos_x,
	output logic signed [oppg_pkg::POS_W-1:0]   pos_y,
	output logic signed [oppg_pkg::POS_W-1:0]   pos_z
);
	import oppg_pkg::*;

	localparam int DIGITS  = STEP_W / DIGIT_W;
	localparam int DIG_CW  = $clog2(DIGITS);
	localparam int IT_W    = $clog2(TRIG_BITS);
	localparam int MAG_W   = TRIG_BITS + 1;          // magnitude clamped to 2^TRIG_BITS
	localparam int SH_W    = TRIG_BITS + 2;          // magnitude before the clamp
	localparam int MSUM_W  = SPEED_W + DIGIT_W;
	localparam int SSUM_W  = MAG_W + DIGIT_W;
	localparam int PROD_W  = SPEED_W + STEP_W;

	localparam logic [MAG_W-1:0] MAG_LIM = MAG_W'(1) << TRIG_BITS;

	// configuration registers
	logic [SPEED_W-1:0]  speed_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [MODE_W-1:0]   mode_q;

	// sequencer
	state_t              state_q, state_nx;
	logic [DIG_CW-1:0]   dig_q;
	logic [IT_W-1:0]     iter_q;
	logic                out_load;

	// speed * step, one step digit per cycle, low digits shift out into mul_lo_q
	logic [STEP_W-1:0]   step_q;
	logic [SPEED_W-1:0]  mul_acc_q;
	logic [STEP_W-1:0]   mul_lo_q;
	logic [MSUM_W-1:0]   mul_sum;
	logic [PROD_W-1:0]   prod_w;

	// phase
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] inc;
	logic [PHASE_BITS-1:0] phase_nx;
	logic [ANGLE_W-1:0]    angle;
	logic                  fold;
	logic [ANGLE_W-1:0]    z_init;

	// CORDIC
	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic                       neg_q;
	logic signed [CORDIC_W-1:0] dx, dy, dz;

	// scaling lanes: s (sine) and c (cosine)
	logic [RADIUS_W-1:0] rad_q;
	logic [MAG_W-1:0]    mag_s_q, mag_c_q;
	logic                sgn_s_q, sgn_c_q;
	logic [MAG_W-1:0]    acc_s_q, acc_c_q;
	logic [RADIUS_W-1:0] lo_s_q, lo_c_q;
	logic [SSUM_W-1:0]   sum_s, sum_c;
	logic signed [CORDIC_W-1:0] x_fin, y_fin;
	logic [RADIUS_W-1:0] prod_s, prod_c;
	logic signed [POS_W-1:0] term_s, term_c;
	logic signed [POS_W-1:0] px, py, pz;

	logic                    out_valid_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;

	// magnitude of a CORDIC value reduced to TRIG_BITS fraction bits and clamped
	function automatic logic [MAG_W-1:0] mag_of(input logic signed [CORDIC_W-1:0] v);
		logic [CORDIC_W-1:0] a;
		logic [SH_W-1:0]     sh;
		a  = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
		sh = SH_W'(a >> (CORDIC_FRAC - TRIG_BITS));
		mag_of = (sh > SH_W'(MAG_LIM)) ? MAG_LIM : sh[MAG_W-1:0];
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= '0;
			radius_q <= '0;
			mode_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPEED:  speed_q  <= cfg_data[SPEED_W-1:0];
				REG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
				REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// serial product: add speed * digit, shift the low digit out
	assign mul_sum = MSUM_W'(mul_acc_q) + MSUM_W'(speed_q) * MSUM_W'(step_q[DIGIT_W-1:0]);
	assign prod_w  = {mul_acc_q, mul_lo_q};

	// align the product and the accumulator to PHASE_BITS
	generate
		if (PHASE_BITS >= ANGLE_W) begin : g_phase_wide
			assign inc   = PHASE_BITS'(prod_w) << (PHASE_BITS - ANGLE_W);
			assign angle = phase_nx[PHASE_BITS-1 -: ANGLE_W];
		end else begin : g_phase_narrow
			assign inc   = PHASE_BITS'(prod_w >> (ANGLE_W - PHASE_BITS));
			assign angle = {phase_nx, {(ANGLE_W - PHASE_BITS){1'b0}}};
		end
	endgenerate

	assign phase_nx = phase_q + inc;

	// beyond a quarter turn either way: take off half a turn and negate the results
	assign fold   = (angle > 32'h4000_0000) && (angle < 32'hC000_0000);
	assign z_init = fold ? {~angle[ANGLE_W-1], angle[ANGLE_W-2:0]} : angle;

	// one rotation per cycle; >>> rounds toward minus infinity
	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;
	assign dz = signed'(ATAN_TURN[ATAN_IDX_W'(iter_q)]);

	assign x_fin = neg_q ? -x_q : x_q;
	assign y_fin = neg_q ? -y_q : y_q;

	// serial radius scaling, both lanes share the radius digit
	assign sum_s = SSUM_W'(acc_s_q) + SSUM_W'(mag_s_q) * SSUM_W'(rad_q[DIGIT_W-1:0]);
	assign sum_c = SSUM_W'(acc_c_q) + SSUM_W'(mag_c_q) * SSUM_W'(rad_q[DIGIT_W-1:0]);

	assign prod_s = RADIUS_W'({acc_s_q, lo_s_q} >> TRIG_BITS);
	assign prod_c = RADIUS_W'({acc_c_q, lo_c_q} >> TRIG_BITS);

	assign term_s = sgn_s_q ? -signed'({1'b0, prod_s}) : signed'({1'b0, prod_s});
	assign term_c = sgn_c_q ? -signed'({1'b0, prod_c}) : signed'({1'b0, prod_c});

	// place the terms; the codes past the list give the origin
	always_comb begin
		px = '0;
		py = '0;
		pz = '0;
		unique case (mode_q)
			AXIS_XY_SC: begin px = term_s; py = term_c; end
			AXIS_XZ_SC: begin px = term_s; pz = term_c; end
			AXIS_XZ_CS: begin px = term_c; pz = term_s; end
			AXIS_XY_CS: begin px = term_c; py = term_s; end
			AXIS_YZ_CS: begin py = term_c; pz = term_s; end
			AXIS_YZ_SC: begin py = term_s; pz = term_c; end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nx = ST_MUL;
			ST_MUL:    if (dig_q == DIG_CW'(DIGITS - 1)) state_nx = ST_ACCUM;
			ST_ACCUM:  state_nx = ST_ROTATE;
			ST_ROTATE: if (iter_q == IT_W'(TRIG_BITS - 1)) state_nx = ST_MAG;
			ST_MAG:    state_nx = ST_SCALE;
			ST_SCALE:  if (dig_q == DIG_CW'(DIGITS - 1)) state_nx = ST_FINISH;
			ST_FINISH: if (!out_valid_q || out_ready) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_FINISH: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dig_q       <= '0;
			iter_q      <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_MUL || state_q == ST_SCALE) begin
				dig_q <= dig_q + DIG_CW'(1);
			end else begin
				dig_q <= '0;
			end
			if (state_q == ST_ROTATE) begin
				iter_q <= iter_q + IT_W'(1);
			end else begin
				iter_q <= '0;
			end
			if (state_q == ST_ACCUM) begin
				phase_q <= phase_nx;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				step_q    <= time_step;
				mul_acc_q <= '0;
				mul_lo_q  <= '0;
			end
			ST_MUL: begin
				step_q    <= step_q >> DIGIT_W;
				mul_acc_q <= SPEED_W'(mul_sum >> DIGIT_W);
				mul_lo_q  <= {mul_sum[DIGIT_W-1:0], mul_lo_q[STEP_W-1:DIGIT_W]};
			end
			ST_ACCUM: begin
				x_q   <= signed'(CORDIC_GAIN);
				y_q   <= '0;
				z_q   <= signed'(z_init);
				neg_q <= fold;
			end
			ST_ROTATE: begin
				if (!z_q[CORDIC_W-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - dz;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + dz;
				end
			end
			ST_MAG: begin
				mag_s_q <= mag_of(y_fin);
				mag_c_q <= mag_of(x_fin);
				sgn_s_q <= y_fin[CORDIC_W-1];
				sgn_c_q <= x_fin[CORDIC_W-1];
				rad_q   <= radius_q;
				acc_s_q <= '0;
				acc_c_q <= '0;
				lo_s_q  <= '0;
				lo_c_q  <= '0;
			end
			ST_SCALE: begin
				rad_q   <= rad_q >> DIGIT_W;
				acc_s_q <= MAG_W'(sum_s >> DIGIT_W);
				acc_c_q <= MAG_W'(sum_c >> DIGIT_W);
				lo_s_q  <= {sum_s[DIGIT_W-1:0], lo_s_q[RADIUS_W-1:DIGIT_W]};
				lo_c_q  <= {sum_c[DIGIT_W-1:0], lo_c_q[RADIUS_W-1:DIGIT_W]};
			end
			default: ;
		endcase
		if (out_load) begin
			pos_x_q <= px;
			pos_y_q <= py;
			pos_z_q <= pz;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign pos_z     = pos_z_q;

endmodule

FILE: dv/orbit_phase_position_generator_core_tb.sv
// Testbench for the orbit phase position generator: predicts every position and checks it.
module orbit_phase_position_generator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import oppg_pkg::*;

	// register index and axis codes that the package leaves unnamed
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [MODE_W-1:0]    AXIS_OFF_6 = 3'd6;
	localparam logic [MODE_W-1:0]    AXIS_OFF_7 = 3'd7;

	localparam int STALL_LIMIT     = 5000;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int RANDOM_PHASES   = 16;
	localparam int ITEMS_PER_PHASE = 106;
	localparam int SETTLE_CYCLES   = 64;

	typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} position_t;

	// Mirror of the register file and the phase accumulator, plus the queue of
	// positions still owed by the block, oldest first.
	class orbit_scoreboard;
		logic [SPEED_W-1:0]  speed;
		logic [RADIUS_W-1:0] radius;
		logic [MODE_W-1:0]   mode;
		logic [63:0]         phase;
		position_t           pending_positions[$];
		int                  failures;

		function new();
			speed    = '0;
			radius   = '0;
			mode     = '0;
			phase    = '0;
			failures = 0;
		endfunction

		function void mirror_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SPEED:  speed  = data[SPEED_W-1:0];
				REG_RADIUS: radius = data[RADIUS_W-1:0];
				REG_MODE:   mode   = data[MODE_W-1:0];
				default: ;
			endcase
		endfunction

		// radius times a 30-bit-fraction trig value, magnitude truncated
		function longint scaled_term(longint v);
			longint mag;
			longint lim;
			lim = longint'(1) << TRIG_BITS_DEF;
			mag = (v < 0) ? -v : v;
			mag = mag >>> (CORDIC_FRAC - TRIG_BITS_DEF);
			if (mag > lim)
				mag = lim;
			mag = (longint'(radius) * mag) >>> TRIG_BITS_DEF;
			return (v < 0) ? -mag : mag;
		endfunction

		function position_t next_position(logic [STEP_W-1:0] step);
			logic [63:0] prod;
			logic [63:0] inc;
			logic [63:0] mask;
			logic [31:0] angle;
			longint      z;
			longint      x;
			longint      y;
			longint      dx;
			longint      dy;
			longint      s;
			longint      c;
			bit          flip;
			int          sh;
			int          i;
			position_t   p;

			sh   = PHASE_BITS_DEF - 32;
			mask = (PHASE_BITS_DEF >= 64) ? '1 : ((64'd1 << PHASE_BITS_DEF) - 64'd1);
			prod = {32'd0, speed} * {48'd0, step};
			inc  = (sh >= 0) ? (prod << sh) : (prod >> (-sh));
			phase = (phase + inc) & mask;
			angle = (sh >= 0) ? 32'(phase >> sh) : 32'(phase << (-sh));

			// fold the signed angle into [-1/4, 1/4] turn, negate both terms after
			z    = longint'(signed'(angle));
			flip = 1'b0;
			if (z > 64'sd1073741824) begin
				z    = z - 64'sd2147483648;
				flip = 1'b1;
			end else if (z < -64'sd1073741824) begin
				z    = z + 64'sd2147483648;
				flip = 1'b1;
			end

			x = longint'(CORDIC_GAIN);
			y = 0;
			for (i = 0; i < TRIG_BITS_DEF && i < ATAN_N; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - longint'(ATAN_TURN[i]);
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + longint'(ATAN_TURN[i]);
				end
			end
			if (flip) begin
				x = -x;
				y = -y;
			end

			s = scaled_term(y);
			c = scaled_term(x);
			p = '0;
			case (mode)
				AXIS_XY_SC: begin p.x = s[POS_W-1:0]; p.y = c[POS_W-1:0]; end
				AXIS_XZ_SC: begin p.x = s[POS_W-1:0]; p.z = c[POS_W-1:0]; end
				AXIS_XZ_CS: begin p.x = c[POS_W-1:0]; p.z = s[POS_W-1:0]; end
				AXIS_XY_CS: begin p.x = c[POS_W-1:0]; p.y = s[POS_W-1:0]; end
				AXIS_YZ_CS: begin p.y = c[POS_W-1:0]; p.z = s[POS_W-1:0]; end
				AXIS_YZ_SC: begin p.y = s[POS_W-1:0]; p.z = c[POS_W-1:0]; end
				default: ;
			endcase
			return p;
		endfunction

		function void note_input(logic [STEP_W-1:0] step);
			pending_positions.push_back(next_position(step));
		endfunction

		function void check_result(logic signed [POS_W-1:0] got_x,
				logic signed [POS_W-1:0] got_y, logic signed [POS_W-1:0] got_z);
			position_t want;
			if (pending_positions.size() == 0) begin
				$error("position with no transaction pending: x=%0d y=%0d z=%0d",
					got_x, got_y, got_z);
				failures++;
			end else begin
				want = pending_positions.pop_front();
				if (got_x !== want.x) begin
					$error("pos_x: expected %0d, actual %0d", want.x, got_x);
					failures++;
				end
				if (got_y !== want.y) begin
					$error("pos_y: expected %0d, actual %0d", want.y, got_y);
					failures++;
				end
				if (got_z !== want.z) begin
					$error("pos_z: expected %0d, actual %0d", want.z, got_z);
					failures++;
				end
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_data;
	logic                        in_valid;
	logic                        in_ready;
	logic [STEP_W-1:0]           time_step;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [POS_W-1:0]     pos_x;
	logic signed [POS_W-1:0]     pos_y;
	logic signed [POS_W-1:0]     pos_z;

	// set by the stimulus to ask the receiver for one long hold-off
	bit                          hold_off_req;

	orbit_scoreboard position_board = new();

	orbit_phase_position_generator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.time_step (time_step),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Check every position transaction against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			position_board.check_result(pos_x, pos_y, pos_z);
	end

	// Drop the run when neither channel moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("orbit_phase_position_generator_core_tb: FAIL");
		$finish;
	end

	// Receiver: switch between stall patterns every so often; on request hold
	// out_ready low for a long stretch so the block fills and stalls in_ready.
	initial begin : receiver
		rx_pattern_t pattern;
		int          pattern_left;
		int          hold_left;
		int          period;
		int          tick;
		out_ready    = 1'b0;
		pattern      = RX_ALWAYS;
		pattern_left = 0;
		hold_left    = 0;
		period       = 3;
		tick         = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_OFF_CYCLES;
			end
			if (pattern_left == 0) begin
				pattern      = rx_pattern_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(32, 256);
				period       = $urandom_range(2, 6);
			end
			pattern_left--;
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (pattern)
					RX_ALWAYS: out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= (tick % period == 0);
				endcase
			end
		end
	end

	// Offer one time step and hold it until the block takes it.
	task automatic send_step(input logic [STEP_W-1:0] step);
		@(negedge clk);
		in_valid  <= 1'b1;
		time_step <= step;
		do
			@(posedge clk);
		while (!in_ready);
		position_board.note_input(step);
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Stop offering and wait until every predicted position has come out.
	task automatic drain();
		idle_sender(1);
		while (position_board.pending_positions.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		position_board.mirror_reg(idx, data);
	endtask

	// Write all registers back to back; junk in the upper data bits must be
	// masked, and a write to the unused index must change nothing.
	task automatic configure(input logic [SPEED_W-1:0] speed,
			input logic [RADIUS_W-1:0] radius, input logic [MODE_W-1:0] mode);
		write_cfg(REG_SPEED, speed);
		write_cfg(REG_RADIUS, {16'($urandom), radius});
		write_cfg(REG_MODE, {29'($urandom), mode});
		write_cfg(REG_UNUSED, $urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random steps in bursts with random gaps; a quarter of them small so the
	// phase also creeps slowly through the quadrant boundaries.
	task automatic send_random(input int count, input int hold_at);
		int burst;
		int k;
		burst = 0;
		for (k = 0; k < count; k++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 32);
				if ($urandom_range(0, 3) != 0)
					idle_sender($urandom_range(1, 12));
			end
			burst--;
			if (k == hold_at)
				hold_off_req = 1'b1;
			send_step(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255)) : 16'($urandom));
		end
	endtask

	initial begin : stimulus
		logic [SPEED_W-1:0]  speed;
		logic [RADIUS_W-1:0] radius;
		logic [MODE_W-1:0]   mode;
		int                  p;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		time_step    = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_SPEED;
		cfg_data     = '0;
		hold_off_req = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Registers straight out of reset: zero speed and radius.
		send_step(16'hFFFF);
		drain();

		// One turn per second: steps of 0x4000 land exactly on quarter turns,
		// so the angle hits zero, the quarter and the half turn folding points.
		configure(32'h0001_0000, 16'hFFFF, AXIS_XY_SC);
		send_step(16'h0000);
		send_step(16'h4000);
		send_step(16'h4000);
		send_step(16'h4000);
		send_step(16'h4000);
		send_step(16'h2000);
		send_step(16'h4000);
		send_step(16'hFFFF);
		send_step(16'h0001);
		send_step(16'h8000);
		drain();

		// Largest speed and radius: the product uses all 48 bits.
		configure(32'hFFFF_FFFF, 16'hFFFF, AXIS_YZ_SC);
		send_step(16'hFFFF);
		send_step(16'hFFFF);
		send_step(16'h0000);
		send_step(16'h5555);
		send_step(16'hAAAA);
		drain();

		// Axis code with no placement: all coordinates zero.
		configure(32'h1234_5678, 16'hFFFF, AXIS_OFF_7);
		send_step(16'h1000);
		send_step(16'hFFFF);
		drain();

		// Zero radius.
		configure(32'h0003_0000, 16'h0000, AXIS_XZ_CS);
		send_step(16'h3000);
		send_step(16'hFFFF);
		drain();

		// Random phases: the first eight walk every axis code, including the
		// unplaced ones, and force the register extremes.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			mode = (p < 8) ? MODE_W'(p) : MODE_W'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0:       speed = '0;
				1:       speed = '1;
				2:       speed = $urandom_range(0, 32'h3_FFFF);
				default: speed = $urandom;
			endcase
			if (p == 0)
				speed = '0;
			if (p == 3)
				speed = '1;
			radius = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
			if (p == 2)
				radius = '0;
			if (p == 4 || p == 6)
				radius = '1;
			if (mode == AXIS_OFF_6)
				radius = '1;
			configure(speed, radius, mode);
			send_random(ITEMS_PER_PHASE, (p == 5) ? 20 : -1);
			drain();
		end

		// Let any stray position show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (position_board.failures == 0 && position_board.pending_positions.size() == 0)
			$display("orbit_phase_position_generator_core_tb: PASS");
		else
			$display("orbit_phase_position_generator_core_tb: FAIL");
		$finish;
	end

endmodule
